// ----- rtl/snm_pkg.sv -----
// Shared widths, constants and control structs for the sigmoid neuron MAC.
`default_nettype none

package snm_pkg;

   localparam int SNM_DATA_W   = 16;
   localparam int SNM_PROD_W   = 32;
   localparam int SNM_ACC_W    = 42;
   localparam int SNM_OUT_W    = 13;

   // Q1.12 value of 1.0
   localparam logic [SNM_OUT_W-1:0] SNM_ONE_Q12 = 13'd4096;

   // sigmoid grid: 256 intervals of 1/16 over [-8, 8), 2^20 LSBs of Q8.24 each
   localparam int SNM_GRID_POINTS = 256;
   localparam int SNM_GRID_SHIFT  = 20;
   localparam int SNM_ROM_DEPTH   = SNM_GRID_POINTS + 1;
   localparam int SNM_ROM_AW      = 9;
   localparam int SNM_ROM_MID     = 128;
   localparam int SNM_U_W         = 28;
   localparam logic signed [SNM_ACC_W-1:0] SNM_EIGHT_Q24 = 42'sd134217728;

   // exp(-1/16) in Q.30 and the Q.30 one
   localparam int SNM_Q30_W = 31;
   localparam logic [29:0] SNM_SIG_STEP = 30'd1008687096;
   localparam logic [SNM_Q30_W-1:0] SNM_ONE_Q30 = 31'h4000_0000;
   localparam int SNM_PM_W = 61;

   localparam int SNM_SEGMENTS_DEFAULT = 32;

   // result queue between the MAC front and the sigmoid back
   localparam int SNM_QUEUE_DEPTH = 4;
   localparam int SNM_QPTR_W      = 2;
   localparam int SNM_QCNT_W      = 3;

   // shared divider
   localparam int SNM_DIVIDEND_W = 43;
   localparam int SNM_DIVISOR_W  = 32;
   localparam int SNM_QUO_W      = 13;
   localparam int SNM_DCNT_W     = 4;

   typedef struct packed {
      logic                        valid;
      logic signed [SNM_ACC_W-1:0] sum;
   } snm_push_type;

   typedef struct packed {
      logic [SNM_QCNT_W-1:0]       count;
      logic                        empty;
      logic signed [SNM_ACC_W-1:0] head;
   } snm_qstat_type;

   typedef struct packed {
      logic                      start;
      logic [SNM_DIVIDEND_W-1:0] dividend;
      logic [SNM_DIVISOR_W-1:0]  divisor;
   } snm_div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SNM_QUO_W-1:0] quotient;
   } snm_div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/snm_if.sv -----
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface snm_req_if;
   import snm_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [SNM_DATA_W-1:0] activation;
   logic signed [SNM_DATA_W-1:0] weight;
   logic                         last;

   modport source (output valid, output activation, output weight, output last, input ready);
   modport sink   (input valid, input activation, input weight, input last, output ready);
endinterface

interface snm_rsp_if;
   import snm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [SNM_OUT_W-1:0] neuron_value;

   modport source (output valid, output neuron_value, input ready);
   modport sink   (input valid, input neuron_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/snm_front.sv -----
// Front end: multiply-accumulate with saturation, pushes finished sums to the queue.
`default_nettype none

module snm_front
   import snm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   snm_req_if.sink       req,
   input  snm_qstat_type qstat,
   output snm_push_type  push
);

   logic                         s1_vld_ff, s1_vld_in;
   logic                         s1_last_ff, s1_last_in;
   logic signed [SNM_PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic signed [SNM_ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SNM_ACC_W:0]    sum_wide;
   logic signed [SNM_ACC_W-1:0]  sum_sat;
   logic                         pend;
   logic                         accept;

   // a last word in stage 1 still needs a queue slot
   assign pend      = s1_vld_ff & s1_last_ff;
   assign req.ready = ({1'b0, qstat.count} + {{SNM_QCNT_W{1'b0}}, pend})
                      < (SNM_QCNT_W+1)'(SNM_QUEUE_DEPTH);
   assign accept    = req.valid & req.ready;

   always_comb begin
      s1_vld_in  = accept;
      s1_last_in = req.last;
      s1_prod_in = SNM_PROD_W'(req.activation * req.weight);

      sum_wide = {acc_ff[SNM_ACC_W-1], acc_ff}
                 + {{(SNM_ACC_W+1-SNM_PROD_W){s1_prod_ff[SNM_PROD_W-1]}}, s1_prod_ff};
      case (sum_wide[SNM_ACC_W:SNM_ACC_W-1])
         2'b01:   sum_sat = {1'b0, {(SNM_ACC_W-1){1'b1}}};
         2'b10:   sum_sat = {1'b1, {(SNM_ACC_W-1){1'b0}}};
         default: sum_sat = sum_wide[SNM_ACC_W-1:0];
      endcase

      acc_in = acc_ff;
      if (s1_vld_ff) begin
         acc_in = s1_last_ff ? '0 : sum_sat;
      end

      push.valid = pend;
      push.sum   = sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         acc_ff    <= acc_in;
      end
      s1_last_ff <= s1_last_in;
      s1_prod_ff <= s1_prod_in;
   end

endmodule

`default_nettype wire

// ----- rtl/snm_queue.sv -----
// Short FIFO of finished weighted sums between front and back.
`default_nettype none

module snm_queue
   import snm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  snm_push_type  push,
   input  logic          pop,
   output snm_qstat_type qstat
);

   logic signed [SNM_ACC_W-1:0] mem_ff [SNM_QUEUE_DEPTH];
   logic [SNM_QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [SNM_QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [SNM_QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(SNM_QCNT_W-1){1'b0}}, push.valid}
                  - {{(SNM_QCNT_W-1){1'b0}}, pop};
      qstat.count = count_ff;
      qstat.empty = (count_ff == '0);
      qstat.head  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.sum;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/snm_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 13-bit quotient.
`default_nettype none

module snm_div
   import snm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  snm_div_req_type div_req,
   output snm_div_rsp_type div_rsp
);

   localparam int TW = SNM_DIVIDEND_W + 2;

   logic [SNM_DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [SNM_DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [SNM_QUO_W-1:0]      quo_ff, quo_in;
   logic [SNM_DCNT_W-1:0]     cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [TW-1:0]             trial;

   always_comb begin
      trial   = {2'b00, rem_ff} - ({{(TW-SNM_DIVISOR_W){1'b0}}, dvs_ff} << cnt_ff);
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quo_in  = '0;
         cnt_in  = SNM_DCNT_W'(SNM_QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[TW-1]) begin
            rem_in         = trial[SNM_DIVIDEND_W-1:0];
            quo_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
      div_rsp.busy     = busy_ff;
      div_rsp.done     = done_ff;
      div_rsp.quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

// ----- rtl/snm_back.sv -----
// Back end: builds the sigmoid table after reset, then evaluates one sum at a time.
`default_nettype none

module snm_back
   import snm_pkg::*;
#(
   parameter int SIGMOID_SEGMENTS = SNM_SEGMENTS_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  snm_qstat_type   qstat,
   output logic            q_pop,
   output snm_div_req_type div_req,
   input  snm_div_rsp_type div_rsp,
   snm_rsp_if.source       rsp
);

   localparam int BW  = $clog2(SIGMOID_SEGMENTS + 1);
   localparam int KPW = 9 + BW;

   typedef enum logic [11:0] {
      ST_B_DIV  = 12'b0000_0000_0001,
      ST_B_WAIT = 12'b0000_0000_0010,
      ST_B_WR   = 12'b0000_0000_0100,
      ST_B_MIR  = 12'b0000_0000_1000,
      ST_B_MUL  = 12'b0000_0001_0000,
      ST_B_RND  = 12'b0000_0010_0000,
      ST_IDLE   = 12'b0000_0100_0000,
      ST_CLASS  = 12'b0000_1000_0000,
      ST_READ   = 12'b0001_0000_0000,
      ST_MUL    = 12'b0010_0000_0000,
      ST_DIV    = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } snm_state_type;

   snm_state_type state_ff, state_in;

   // breakpoint grid indices
   logic [SNM_ROM_AW-1:0] bkpt_tab [SIGMOID_SEGMENTS+1];
   for (genvar kk = 0; kk <= SIGMOID_SEGMENTS; kk++) begin : g_bkpt
      localparam int Bp = (kk * SNM_GRID_POINTS) / SIGMOID_SEGMENTS;
      assign bkpt_tab[kk] = SNM_ROM_AW'(Bp);
   end

   logic [SNM_OUT_W-1:0] rom_mem [SNM_ROM_DEPTH];
   logic                 rom_we;
   logic [SNM_ROM_AW-1:0] rom_waddr;
   logic [SNM_OUT_W-1:0] rom_wdata;
   logic [SNM_ROM_AW-1:0] rd_addr_a;
   logic [SNM_OUT_W-1:0] rd_a_ff, rd_b_ff;

   logic [SNM_Q30_W-1:0] p_ff, p_in;
   logic [SNM_PM_W-1:0]  pm_ff, pm_in;
   logic [SNM_PM_W-1:0]  pm_rnd;
   logic [7:0]           i_ff, i_in;
   logic [SNM_DIVISOR_W-1:0]  b_den;
   logic [SNM_DIVIDEND_W-1:0] b_num;

   logic signed [SNM_ACC_W-1:0] s_ff, s_in;
   logic signed [SNM_ACC_W-1:0] u_full;
   logic                 hi_ff, hi_in, lo_ff, lo_in;
   logic [SNM_U_W-1:0]   u_ff, u_in;
   logic [SNM_ROM_AW-1:0] bl_ff, bl_in, br_ff, br_in;
   logic [8:0]           g1;
   logic [KPW-1:0]       kp;
   logic [BW:0]          k_full;
   logic [BW-1:0]        k, k1;
   logic [SNM_ROM_AW+SNM_GRID_SHIFT-1:0] dx_full;
   logic [SNM_OUT_W-1:0] dy;

   logic [SNM_OUT_W-1:0] res_ff, res_in;
   logic                 out_vld_ff, out_vld_in;
   logic [SNM_OUT_W-1:0] out_val_ff, out_val_in;

   always_comb begin
      // table build arithmetic
      b_den  = {1'b0, SNM_ONE_Q30} + {1'b0, p_ff};
      b_num  = {1'b1, {(SNM_DIVIDEND_W-1){1'b0}}}
               + {{(SNM_DIVIDEND_W-SNM_DIVISOR_W+1){1'b0}}, b_den[SNM_DIVISOR_W-1:1]};
      pm_rnd = pm_ff + (SNM_PM_W'(1) << 29);

      // classification of the sum
      u_full = s_ff + SNM_EIGHT_Q24;
      g1     = {1'b0, u_full[SNM_U_W-1:SNM_GRID_SHIFT]} + 9'd1;
      kp     = KPW'(g1) * KPW'(SIGMOID_SEGMENTS) + KPW'(SNM_GRID_POINTS - 1);
      k_full = kp[KPW-1:8] - (BW+1)'(1);
      k      = k_full[BW-1:0];
      k1     = k + BW'(1);

      // interpolation terms
      dx_full = {1'b0, u_ff} - {bl_ff, {SNM_GRID_SHIFT{1'b0}}};
      dy      = rd_b_ff - rd_a_ff;

      if (hi_ff) begin
         rd_addr_a = SNM_ROM_AW'(SNM_GRID_POINTS);
      end else if (lo_ff) begin
         rd_addr_a = '0;
      end else begin
         rd_addr_a = bl_ff;
      end

      state_in   = state_ff;
      p_in       = p_ff;
      pm_in      = pm_ff;
      i_in       = i_ff;
      s_in       = s_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      u_in       = u_ff;
      bl_in      = bl_ff;
      br_in      = br_ff;
      res_in     = res_ff;
      out_vld_in = out_vld_ff & ~rsp.ready;
      out_val_in = out_val_ff;
      q_pop      = 1'b0;
      rom_we     = 1'b0;
      rom_waddr  = SNM_ROM_AW'(SNM_ROM_MID) + {1'b0, i_ff};
      rom_wdata  = res_ff;
      div_req.start    = 1'b0;
      div_req.dividend = b_num;
      div_req.divisor  = b_den;

      unique case (state_ff)
         ST_B_DIV: begin
            div_req.start = 1'b1;
            state_in      = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quotient;
               state_in = ST_B_WR;
            end
         end
         ST_B_WR: begin
            rom_we   = 1'b1;
            state_in = ST_B_MIR;
         end
         ST_B_MIR: begin
            rom_we    = (i_ff != '0);
            rom_waddr = SNM_ROM_AW'(SNM_ROM_MID) - {1'b0, i_ff};
            rom_wdata = SNM_ONE_Q12 - res_ff;
            state_in  = ST_B_MUL;
         end
         ST_B_MUL: begin
            pm_in    = SNM_PM_W'(p_ff) * SNM_PM_W'(SNM_SIG_STEP);
            state_in = ST_B_RND;
         end
         ST_B_RND: begin
            p_in = pm_rnd[SNM_Q30_W+29:30];
            if (i_ff == 8'(SNM_ROM_MID)) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_B_DIV;
            end
         end
         ST_IDLE: begin
            if (!qstat.empty) begin
               q_pop    = 1'b1;
               s_in     = qstat.head;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            hi_in    = (s_ff >= SNM_EIGHT_Q24);
            lo_in    = (s_ff < -SNM_EIGHT_Q24);
            u_in     = u_full[SNM_U_W-1:0];
            bl_in    = bkpt_tab[k];
            br_in    = bkpt_tab[k1];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (hi_ff || lo_ff) begin
               res_in   = rd_a_ff;
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = SNM_DIVIDEND_W'(dy * dx_full[SNM_U_W-1:0]);
               div_req.divisor  = SNM_DIVISOR_W'({br_ff - bl_ff, {SNM_GRID_SHIFT{1'b0}}});
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in   = rd_a_ff + div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp.ready) begin
               out_vld_in = 1'b1;
               out_val_in = res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_B_DIV;
      endcase

      rsp.valid        = out_vld_ff;
      rsp.neuron_value = out_val_ff;
   end

   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[rom_waddr] <= rom_wdata;
      end
      rd_a_ff <= rom_mem[rd_addr_a];
      rd_b_ff <= rom_mem[br_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_B_DIV;
         p_ff       <= SNM_ONE_Q30;
         i_ff       <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_ff       <= p_in;
         i_ff       <= i_in;
         out_vld_ff <= out_vld_in;
      end
      pm_ff      <= pm_in;
      s_ff       <= s_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      u_ff       <= u_in;
      bl_ff      <= bl_in;
      br_ff      <= br_in;
      res_ff     <= res_in;
      out_val_ff <= out_val_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sigmoid_neuron_mac_top.sv -----
// Top level of the sigmoid neuron MAC: front, queue, back and shared divider.
//
//   channel   dir  handshake     word
//   req_chan  in   valid/ready   activation, weight, last
//   rsp_chan  out  valid/ready   neuron_value
//
// The front takes one word per cycle while the queue has room (one 16x16
// multiply, one 42-bit add). A sum inside [-8, 8) is evaluated by the back
// through the 13-step divider; one outside it takes the table end value.
// Four sums can wait in the queue. After reset the back builds its 257-entry
// table in 129 steps; words are taken meanwhile until the queue fills.
// A stalled response holds in the output register while the back moves on.
`default_nettype none

module sigmoid_neuron_mac_top
   import snm_pkg::*;
#(
   parameter int SIGMOID_SEGMENTS = SNM_SEGMENTS_DEFAULT
)
(
   input logic        clock,
   input logic        reset,
   snm_req_if.sink    req_chan,
   snm_rsp_if.source  rsp_chan
);

   snm_push_type    push;
   snm_qstat_type   qstat;
   logic            q_pop;
   snm_div_req_type div_req;
   snm_div_rsp_type div_rsp;

   snm_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .qstat (qstat),
      .push  (push)
   );

   snm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .qstat (qstat)
   );

   snm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   snm_back #(
      .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .q_pop   (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp     (rsp_chan)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (qstat.count != SNM_QCNT_W'(SNM_QUEUE_DEPTH)) || q_pop)
      else $error("queue overflow");

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.neuron_value <= SNM_ONE_Q12))
      else $error("neuron value above 1.0");

endmodule

`default_nettype wire

// ----- tb/sigmoid_neuron_mac_top_tb.sv -----
// Testbench for the sigmoid neuron MAC: random and directed fan-ins checked against a local model.
`timescale 1ns / 100ps

module sigmoid_neuron_mac_top_tb;
   import snm_pkg::*;

   localparam int     SEGS    = SNM_SEGMENTS_DEFAULT;
   localparam longint ACC_HI  = (64'sd1 <<< 41) - 1;
   localparam longint ACC_LO  = -(64'sd1 <<< 41);
   localparam longint EIGHT   = 64'sd1 <<< 27;
   localparam int     PHASE_WORDS = 85;

   typedef struct packed {
      logic signed [SNM_DATA_W-1:0] activation;
      logic signed [SNM_DATA_W-1:0] weight;
      logic                         last;
   } mac_word_type;

   typedef enum int {MIX_SMALL, MIX_FULL, MIX_CORNER} mix_type;
   typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_type;

   logic clock;
   logic reset;

   snm_req_if req_chan();
   snm_rsp_if rsp_chan();

   sigmoid_neuron_mac_top #(.SIGMOID_SEGMENTS(SEGS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mac_word_type         pending_words[$];
   logic [SNM_OUT_W-1:0] expected_values[$];
   logic [SNM_OUT_W-1:0] sig_table [0:SNM_ROM_DEPTH-1];
   longint               mac_sum;
   int                   src_idle_pct = 0;
   int                   snk_stall_pct = 0;
   int                   errors = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("sigmoid_neuron_mac_top_tb: done, errors");
      $finish;
   end

   function automatic logic signed [SNM_DATA_W-1:0] pick_value(mix_type mix);
      int r;
      r = $urandom_range(99);
      if (mix == MIX_SMALL || (mix == MIX_CORNER && r >= 15 && r < 55))
         return 16'(int'($urandom_range(16383)) - 8192);
      if (mix == MIX_FULL || (mix == MIX_CORNER && r >= 55))
         return 16'($urandom);
      case ($urandom_range(6))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return 16'sd4096;
         4: return -16'sd4096;
         5: return 16'sd1;
         default: return -16'sd1;
      endcase
   endfunction

   task automatic push_word(int a, int w, bit last);
      mac_word_type wd;
      wd.activation = 16'(a);
      wd.weight     = 16'(w);
      wd.last       = last;
      pending_words.insert(pending_words.size(), wd);
   endtask

   task automatic queue_fanin(int n, mix_type mix);
      mac_word_type wd;
      for (int i = 0; i < n; i++) begin
         wd.activation = pick_value(mix);
         wd.weight     = pick_value(mix);
         wd.last       = (i == n - 1);
         pending_words.insert(pending_words.size(), wd);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || expected_values.size() != 0);
   endtask

   // accept side: predict on each accepted word, then present the next one
   always @(posedge clock) begin : drive_words
      longint            prod;
      longint            sum;
      longint unsigned   u, g, k, bl, br, yl, yr, val;
      mac_word_type      nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         mac_sum = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            prod = longint'(req_chan.activation) * longint'(req_chan.weight);
            sum = mac_sum + prod;
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            mac_sum = sum;
            if (req_chan.last) begin
               if (sum >= EIGHT) begin
                  val = sig_table[256];
               end else if (sum < -EIGHT) begin
                  val = sig_table[0];
               end else begin
                  u = sum + EIGHT;
                  g = u >> SNM_GRID_SHIFT;
                  k = ((g + 1) * SEGS + 255) / 256 - 1;
                  bl = (k * 256) / SEGS;
                  br = ((k + 1) * 256) / SEGS;
                  if (br > 256) br = 256;
                  if (bl >= br) begin
                     val = sig_table[bl & 255];
                  end else begin
                     yl = sig_table[bl];
                     yr = sig_table[br];
                     val = yl + ((yr - yl) * (u - (bl << SNM_GRID_SHIFT)))
                           / ((br << SNM_GRID_SHIFT) - (bl << SNM_GRID_SHIFT));
                  end
               end
               expected_values.insert(expected_values.size(), val[SNM_OUT_W-1:0]);
               mac_sum = 0;
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               nxt = pending_words.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.activation <= nxt.activation;
               req_chan.weight     <= nxt.weight;
               req_chan.last       <= nxt.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_values
      logic [SNM_OUT_W-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_values.size() == 0) begin
               errors++;
               $display("%0t: unexpected neuron value, expected none, actual %0d",
                        $time, rsp_chan.neuron_value);
            end else begin
               want = expected_values.pop_front();
               if (rsp_chan.neuron_value !== want) begin
                  errors++;
                  $display("%0t: neuron_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_chan.neuron_value);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   initial begin : run
      longint unsigned p, den, num;
      int              n, r, count;
      mix_type         mix;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.activation = '0;
      req_chan.weight     = '0;
      req_chan.last       = 1'b0;
      rsp_chan.ready      = 1'b0;

      // sigmoid table, upper half from exp(-x) in Q.30, lower half by symmetry
      p = 64'd1 << 30;
      for (int i = 0; i <= SNM_ROM_MID; i++) begin
         den = (64'd1 << 30) + p;
         num = (64'd4096 << 30) + den / 2;
         sig_table[SNM_ROM_MID + i] = SNM_OUT_W'(num / den);
         p = (p * SNM_SIG_STEP + (64'd1 << 29)) >> 30;
      end
      for (int i = 0; i < SNM_ROM_MID; i++)
         sig_table[i] = SNM_ONE_Q12 - sig_table[SNM_GRID_POINTS - i];

      // directed: zero, both ends of the sigmoid range, product extremes, short sums
      push_word(0, 0, 1);
      push_word(4096, -32768, 1);
      push_word(-4096, -32768, 1);
      push_word(4096, 32767, 1);
      push_word(-4097, 32767, 1);
      push_word(1, 1, 1);
      push_word(-1, 1, 1);
      push_word(4096, -30720, 1);
      push_word(32767, 32767, 1);
      push_word(-32768, -32768, 1);
      push_word(-32768, 32767, 1);
      push_word(32767, -32768, 1);
      push_word(4096, 4096, 0);
      push_word(4096, -8192, 0);
      push_word(2048, 4096, 1);
      push_word(-32768, -32768, 0);
      push_word(-32768, 32767, 1);
      push_word(0, 0, 0);
      push_word(4096, 12288, 1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // long fan-ins that swing the sum from one end of the sigmoid to the other
      for (int i = 0; i < 40; i++) push_word(-32768, -32768, 0);
      for (int i = 0; i < 44; i++) push_word(-32768, 32767, i == 43);
      for (int i = 0; i < 40; i++) push_word(-32768, 32767, 0);
      for (int i = 0; i < 44; i++) push_word(-32768, -32768, i == 43);
      wait_drained();

      for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
         case (phase_type'(ph))
            PH_FREE:      begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
            PH_SRC_IDLE:  begin src_idle_pct <= 65; snk_stall_pct <= 0;  end
            PH_SNK_STALL: begin src_idle_pct <= 0;  snk_stall_pct <= 65; end
            default:      begin src_idle_pct <= 16; snk_stall_pct <= 16; end
         endcase
         count = 0;
         while (count < PHASE_WORDS) begin
            r = $urandom_range(99);
            if (r < 80)      n = $urandom_range(8, 1);
            else if (r < 95) n = $urandom_range(24, 9);
            else             n = $urandom_range(60, 25);
            r = $urandom_range(99);
            mix = (r < 50) ? MIX_SMALL : ((r < 80) ? MIX_CORNER : MIX_FULL);
            queue_fanin(n, mix);
            count += n;
         end
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("sigmoid_neuron_mac_top_tb: done, clean");
      else
         $display("sigmoid_neuron_mac_top_tb: done, errors");
      $finish;
   end

endmodule
